>>> hdl/tfig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfig_pkg: shared types and constants for the triangle fan index generator
// Field widths, the shared-adder operand codes and the control/status bundles.
// ----------------------------------------------------------------------------
package tfig_pkg;

  localparam int IDX_W      = 18;   // vertex index / counters
  localparam int VC_W       = 7;    // vertex count field
  localparam int NEED_W     = 8;    // 3*(verts-2), at most 192
  localparam int SUM_W      = IDX_W + 1;
  localparam int IN_DATA_W  = 8;    // vertex_count padded to a byte
  localparam int OUT_DATA_W = 56;   // three corners padded to whole bytes

  localparam logic [IDX_W-1:0] CAPACITY_RESET = IDX_W'(36000 * 6);

  // operand pairs for the shared adder
  typedef enum logic [1:0] {
    OP_CNT_NEED  = 2'd0,  // index_count + needed indices
    OP_BASE_VERT = 2'd1,  // base + vertex count (short polygon)
    OP_BASE_ONE  = 2'd2,  // base + 1, first corner_b
    OP_RUN_ONE   = 2'd3   // running corner + 1
  } op_sel_t;

  typedef struct packed {
    op_sel_t op;
    logic    item_load;
    logic    pend_we;
    logic    base_we;
    logic    count_we;
    logic    run_we;
    logic    tri_load;
    logic    tri_dec;
    logic    out_load;
    logic    out_flush;
  } ctrl_t;

  typedef struct packed {
    logic short_poly;
    logic over;
    logic last_tri;
  } stat_t;

endpackage

>>> hdl/tfig_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfig_dp: datapath of the triangle fan index generator
// Counters, capacity register and the one adder shared by every addition step.
// ----------------------------------------------------------------------------
module tfig_dp #(
  parameter int MAX_POLY_VERTICES = 66
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tfig_pkg::VC_W-1:0] vertex_count,
  input  logic                      new_batch,
  input  logic                      cfg_wr_en,
  input  logic [tfig_pkg::IDX_W-1:0] cfg_wr_data,
  input  tfig_pkg::ctrl_t           ctrl,
  output tfig_pkg::stat_t           stat,
  output logic [tfig_pkg::IDX_W-1:0] corner_a,
  output logic [tfig_pkg::IDX_W-1:0] corner_b,
  output logic [tfig_pkg::IDX_W-1:0] corner_c
);
  import tfig_pkg::*;

  localparam logic [VC_W-1:0] VMAX = VC_W'(MAX_POLY_VERTICES);

  logic [IDX_W-1:0]  cap_r, base_r, count_r, run_r;
  logic [VC_W-1:0]   verts_r, tri_left_r, verts_sat;
  logic [SUM_W-1:0]  pend_r, sum;
  logic [IDX_W-1:0]  op_a, op_b;
  logic [NEED_W+1:0] need_full;
  logic [NEED_W-1:0] need;

  assign verts_sat = (vertex_count > VMAX) ? VMAX : vertex_count;

  // 3*v - 6, only looked at when v >= 3
  assign need_full = ({3'b000, verts_r} << 1) + {3'b000, verts_r} - (NEED_W+2)'(6);
  assign need      = need_full[NEED_W-1:0];

  // shared adder
  always_comb begin
    case (ctrl.op)
      OP_CNT_NEED: begin
        op_a = count_r;
        op_b = IDX_W'(need);
      end
      OP_BASE_VERT: begin
        op_a = base_r;
        op_b = IDX_W'(verts_r);
      end
      OP_BASE_ONE: begin
        op_a = base_r;
        op_b = IDX_W'(1);
      end
      OP_RUN_ONE: begin
        op_a = run_r;
        op_b = IDX_W'(1);
      end
      default: begin
        op_a = count_r;
        op_b = IDX_W'(need);
      end
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, op_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAPACITY_RESET;
      base_r  <= '0;
      count_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (ctrl.item_load && new_batch) begin
        base_r  <= '0;
        count_r <= '0;
      end else begin
        if (ctrl.base_we) begin
          base_r <= sum[IDX_W-1:0];
        end
        // pend never exceeds the capacity once committed
        if (ctrl.count_we) begin
          count_r <= pend_r[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.item_load) begin
      verts_r <= verts_sat;
    end
    if (ctrl.pend_we) begin
      pend_r <= sum;
    end
    if (ctrl.run_we) begin
      run_r <= sum[IDX_W-1:0];
    end
    if (ctrl.tri_load) begin
      tri_left_r <= verts_r - VC_W'(2);
    end else if (ctrl.tri_dec) begin
      tri_left_r <= tri_left_r - VC_W'(1);
    end
  end

  assign stat.short_poly = (verts_r < VC_W'(3));
  assign stat.over       = (pend_r > {1'b0, cap_r});
  assign stat.last_tri   = (tri_left_r == VC_W'(1));

  assign corner_a = base_r;
  assign corner_b = run_r;
  assign corner_c = sum[IDX_W-1:0];

endmodule

>>> hdl/tfig_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfig_ctrl: sequencer of the triangle fan index generator
// Steps one polygon through check, evaluation, fan emission or need-flush, and counter commit.
// ----------------------------------------------------------------------------
module tfig_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic            slot_free,
  input  tfig_pkg::stat_t stat,
  output logic            in_ready,
  output tfig_pkg::ctrl_t ctrl
);
  import tfig_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_EVAL  = 6'b000100,
    S_INIT  = 6'b001000,
    S_TRI   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;  // commit step after the last triangle

  always_comb begin
    ctrl      = '0;
    ctrl.op   = OP_CNT_NEED;
    in_ready  = 1'b0;
    state_nxt = state_r;
    done_nxt  = 1'b0;
    if (done_r) begin
      // base <- last corner_c + 1, count <- pending sum
      ctrl.op       = OP_RUN_ONE;
      ctrl.base_we  = 1'b1;
      ctrl.count_we = 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          in_ready = 1'b1;
          if (in_accept) begin
            ctrl.item_load = 1'b1;
            state_nxt      = S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.short_poly) begin
            ctrl.op      = OP_BASE_VERT;
            ctrl.base_we = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            ctrl.op      = OP_CNT_NEED;
            ctrl.pend_we = 1'b1;
            state_nxt    = S_EVAL;
          end
        end
        S_EVAL: begin
          state_nxt = stat.over ? S_FLUSH : S_INIT;
        end
        S_INIT: begin
          ctrl.op       = OP_BASE_ONE;
          ctrl.run_we   = 1'b1;
          ctrl.tri_load = 1'b1;
          state_nxt     = S_TRI;
        end
        S_TRI: begin
          ctrl.op = OP_RUN_ONE;
          if (slot_free) begin
            ctrl.out_load = 1'b1;
            ctrl.run_we   = 1'b1;
            ctrl.tri_dec  = 1'b1;
            if (stat.last_tri) begin
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            ctrl.out_load  = 1'b1;
            ctrl.out_flush = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      // commit step sits in IDLE; done_r keeps in_ready low meanwhile
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

>>> hdl/triangle_fan_index_generator_unit.sv
`timescale 1ns / 1ps
// A polygon word is accepted in IDLE and passes CHECK, EVAL and INIT; TRI then loads its
// first triangle word into the output register. A polygon of n >= 3 vertices runs check,
//   evaluate, setup, one triangle per cycle through the shared adder while the output
//   register has room, and commit. Polygons under 3 vertices end after check, and a
//   need-flush polygon after its flush word, which also waits for room in the register.
// Reset (rst_n low, synchronous): base and count clear, capacity returns to 216000.
// ----------------------------------------------------------------------------
// triangle_fan_index_generator_unit: triangle fan to triangle list indices
// Emits one (base, base+i+1, base+i+2) index triple per word for each fan
// triangle of a polygon, or a single need-flush word when the batch is full.
// ----------------------------------------------------------------------------
module triangle_fan_index_generator_unit #(
  parameter int MAX_POLY_VERTICES = 66
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tfig_pkg::IN_DATA_W-1:0]   in_tdata,   // [6:0] vertex_count, [7] zero
  input  logic                             in_tuser,   // new_batch
  // result words
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tfig_pkg::OUT_DATA_W-1:0]  out_tdata,  // [17:0] corner_a, [35:18] corner_b,
                                                       // [53:36] corner_c, [55:54] zero
  output logic                             out_tlast,  // last
  output logic                             out_tuser,  // need_flush
  // capacity register
  input  logic                             cfg_wr_en,
  input  logic [tfig_pkg::IDX_W-1:0]       cfg_wr_data
);
  import tfig_pkg::*;

  ctrl_t            ctrl;
  stat_t            stat;
  logic             in_accept;
  logic             slot_free;
  logic [IDX_W-1:0] corner_a, corner_b, corner_c;

  // output register: decouples the sequencer from downstream backpressure
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  logic                  out_flush_r;

  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Sequencer, for a fan that fits: IDLE takes a word, then check / evaluate / setup, then
  // one triangle per cycle while the output register has room, then commit.
  tfig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .slot_free (slot_free),
    .stat      (stat),
    .in_ready  (in_tready),
    .ctrl      (ctrl)
  );

  // Datapath: counters, capacity and the single shared 19-bit adder.
  tfig_dp #(
    .MAX_POLY_VERTICES (MAX_POLY_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_count (in_tdata[VC_W-1:0]),
    .new_batch    (in_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .ctrl         (ctrl),
    .stat         (stat),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      // flush word carries zero corners and closes the polygon
      if (ctrl.out_flush) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= OUT_DATA_W'({corner_c, corner_b, corner_a});
      end
      out_last_r  <= ctrl.out_flush || stat.last_tri;
      out_flush_r <= ctrl.out_flush;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_flush_r;

  // a flush word has zero corners and is the last word of its polygon
  a_flush_word : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0) && out_tlast)
    else $error("flush word malformed");

  // every triangle word has corner_c one above corner_b
  a_tri_adjacent : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[3*IDX_W-1:2*IDX_W] == out_tdata[2*IDX_W-1:IDX_W] + IDX_W'(1))
    else $error("corner_c not adjacent to corner_b");

  // the sequencer only loads a word when the output register has room
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> slot_free)
    else $error("output word overwritten");

endmodule

>>> sim/tfig_fan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfig_fan_checker: fan triangulation predictor and result word checker
// Watches the polygon, result and capacity ports of the index generator,
// predicts every triangle or need-flush word and compares them in order.
// ----------------------------------------------------------------------------
module tfig_fan_checker #(
  parameter int MAX_VERTS = 66
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tfig_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tfig_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             out_tlast,
  input  logic                             out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [tfig_pkg::IDX_W-1:0]       cfg_wr_data,
  output int                               fail_count,
  output int                               words_due
);

  localparam int IDX_W = tfig_pkg::IDX_W;
  localparam int VC_W  = tfig_pkg::VC_W;

  typedef struct packed {
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic             last;
    logic             need_flush;
  } tri_word_t;

  tri_word_t        fan_words_due[$];
  logic [IDX_W-1:0] capacity;
  logic [IDX_W-1:0] base_idx;
  logic [IDX_W-1:0] idx_count;
  int               fails = 0;

  assign fail_count = fails;
  assign words_due  = fan_words_due.size();

  // queue the triangles (or the flush word) one polygon produces
  task automatic predict_fan(input logic [VC_W-1:0] verts_in, input logic fresh);
    int unsigned verts;
    int unsigned tris;
    int unsigned needed;
    tri_word_t   w;
    begin
      verts = verts_in;
      if (fresh) begin
        base_idx  = '0;
        idx_count = '0;
      end
      if (verts > MAX_VERTS) verts = MAX_VERTS;
      if (verts < 3) begin
        base_idx = base_idx + IDX_W'(verts);
      end else begin
        tris   = verts - 2;
        needed = 3 * tris;
        if (int'(idx_count) + needed > int'(capacity)) begin
          w = '{corner_a: '0, corner_b: '0, corner_c: '0, last: 1'b1, need_flush: 1'b1};
          fan_words_due.push_back(w);
        end else begin
          for (int unsigned i = 0; i < tris; i++) begin
            w.corner_a   = base_idx;
            w.corner_b   = base_idx + IDX_W'(i + 1);
            w.corner_c   = base_idx + IDX_W'(i + 2);
            w.last       = (i + 1 == tris);
            w.need_flush = 1'b0;
            fan_words_due.push_back(w);
          end
          base_idx  = base_idx + IDX_W'(verts);
          idx_count = idx_count + IDX_W'(needed);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    begin
      if (want != got) begin
        fails++;
        if (fails <= 50)
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    tri_word_t w;
    if (!rst_n) begin
      capacity  = tfig_pkg::CAPACITY_RESET;
      base_idx  = '0;
      idx_count = '0;
      fan_words_due.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_tvalid && in_tready) predict_fan(in_tdata[VC_W-1:0], in_tuser);
      if (out_tvalid && out_tready) begin
        if (fan_words_due.size() == 0) begin
          fails++;
          if (fails <= 50)
            $display("%0t: unexpected result word, expected none actual %h last %b flush %b",
                     $time, out_tdata, out_tlast, out_tuser);
        end else begin
          w = fan_words_due.pop_front();
          check_field("corner_a", w.corner_a, out_tdata[IDX_W-1:0]);
          check_field("corner_b", w.corner_b, out_tdata[2*IDX_W-1:IDX_W]);
          check_field("corner_c", w.corner_c, out_tdata[3*IDX_W-1:2*IDX_W]);
          check_field("last", w.last, out_tlast);
          check_field("need_flush", w.need_flush, out_tuser);
        end
      end
    end
  end

endmodule

>>> sim/triangle_fan_index_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_fan_index_generator_unit_tb: top of the index generator bench
// Drives polygon words and capacity writes, throttles the result side, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module triangle_fan_index_generator_unit_tb;

  import tfig_pkg::*;

  localparam int MAX_VERTS      = 66;
  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 12;
  // margin for the unit to retire a short or need-flush polygon
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int RAND_PER_PHASE = 82;
  // worst case ~300 polygons x 64 triangles under heavy stalls, several times over
  localparam int CYCLE_LIMIT    = 600000;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;   // [6:0] vertex_count, [7] zero
  logic                  in_tuser    = 1'b0; // new_batch
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // corner_a, corner_b, corner_c, pad
  logic                  out_tlast;          // last
  logic                  out_tuser;          // need_flush
  logic                  cfg_wr_en   = 1'b0;
  logic [IDX_W-1:0]      cfg_wr_data = '0;

  int fail_count;
  int words_due;
  int cycles        = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 45;
  bit hold_req      = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  triangle_fan_index_generator_unit #(
    .MAX_POLY_VERTICES(MAX_VERTS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  tfig_fan_checker #(
    .MAX_VERTS(MAX_VERTS)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random back-pressure at the current rate. One long hold-off
  // on request lets the unit fill up and drop in_tready while words keep coming.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one polygon word; random gaps ahead of it. Valid stays high after
  // acceptance so back-to-back words need no extra toggle.
  task automatic send_polygon(input logic [VC_W-1:0] verts, input logic fresh);
    begin
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {1'b0, verts};
      in_tuser  <= fresh;
      do @(posedge clk); while (!in_tready);
    end
  endtask

  // Drop valid, wait until every predicted word has come out, then let the
  // unit finish any short or need-flush polygon still in flight.
  task automatic wait_idle();
    begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      while (words_due != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
  endtask

  // capacity writes only happen with the unit idle
  task automatic set_capacity(input logic [IDX_W-1:0] value);
    begin
      wait_idle();
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= value;
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
    end
  endtask

  initial begin
    int unsigned pick;
    logic [VC_W-1:0] verts;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: reset capacity, basic fans, short polygons, saturation
    send_polygon(7'd3, 1'b0);
    send_polygon(7'd4, 1'b0);
    send_polygon(7'd0, 1'b0);     // short polygons only move the base
    send_polygon(7'd1, 1'b0);
    send_polygon(7'd2, 1'b0);
    send_polygon(7'd66, 1'b0);    // largest legal fan, 64 triangles
    send_polygon(7'd67, 1'b0);    // clamps to the vertex limit
    send_polygon(7'd127, 1'b1);   // all ones, fresh batch
    send_polygon(7'd5, 1'b1);

    // zero capacity: every real polygon asks for a flush
    set_capacity('0);
    send_polygon(7'd3, 1'b0);
    send_polygon(7'd2, 1'b0);
    send_polygon(7'd127, 1'b1);   // clear still happens ahead of the flush
    send_polygon(7'd0, 1'b1);
    send_polygon(7'd4, 1'b0);

    // full-scale capacity
    set_capacity('1);
    send_polygon(7'd66, 1'b0);
    send_polygon(7'd66, 1'b0);
    send_polygon(7'd3, 1'b1);

    // capacity of two triangles: exact fit, then one triangle too many
    set_capacity(IDX_W'(6));
    send_polygon(7'd3, 1'b1);
    send_polygon(7'd3, 1'b0);
    send_polygon(7'd3, 1'b0);
    send_polygon(7'd4, 1'b1);
    send_polygon(7'd3, 1'b0);
    send_polygon(7'd1, 1'b0);

    // --- random phases: each gets its own capacity and idle mix
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          set_capacity(IDX_W'($urandom_range(30, 900)));   // flushes are common
          send_idle_pct = 21;
          recv_idle_pct = 45;
        end
        1: begin
          set_capacity(IDX_W'($urandom_range(1000, 262142)));
          send_idle_pct = 45;
          recv_idle_pct = 21;
        end
        default: begin
          set_capacity(CAPACITY_RESET);
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // mostly small fans, some short, a few large and a few over the limit
        pick = $urandom_range(0, 99);
        if (pick < 10)      verts = VC_W'($urandom_range(0, 2));
        else if (pick < 75) verts = VC_W'($urandom_range(3, 8));
        else if (pick < 93) verts = VC_W'($urandom_range(9, MAX_VERTS));
        else                verts = VC_W'($urandom_range(MAX_VERTS + 1, 127));
        send_polygon(verts, $urandom_range(0, 9) == 0);
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
hdl/tfig_pkg.sv
hdl/tfig_dp.sv
hdl/tfig_ctrl.sv
hdl/triangle_fan_index_generator_unit.sv
sim/tfig_fan_checker.sv
sim/triangle_fan_index_generator_unit_tb.sv
